// File: rtl/deq_pkg.sv
package deq_pkg;

    localparam int WORD_W        = 32;
    localparam int KIND_W        = 3;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOK       = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_PUSH_REAR  = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_POP_REAR   = 3'd4
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } state_t;

    typedef logic signed [WORD_W-1:0] word_t;

    // ends and flags of one result, occupancy travels beside it
    typedef struct packed {
        word_t front_value;
        word_t rear_value;
        logic  is_empty;
        logic  is_full;
        logic  op_error;
    } res_t;

endpackage

// File: rtl/deq_in_if.sv
interface deq_in_if
    import deq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink (input valid, input kind, input push_value, output ready);
endinterface

// File: rtl/deq_out_if.sv
interface deq_out_if
    import deq_pkg::*;
#(
    parameter int OCC_W = 7
) ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic                     op_error;
    logic [OCC_W-1:0]         occupancy;

    modport source (
        output valid, output front_value, output rear_value, output is_empty,
        output is_full, output op_error, output occupancy, input ready
    );
    modport sink (
        input valid, input front_value, input rear_value, input is_empty,
        input is_full, input op_error, input occupancy, output ready
    );
endinterface

// File: rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit words held in a ring buffer of DEPTH
// entries in a single-port-write, registered-read RAM. Every accepted request
// returns exactly one response carrying the front and rear words (-1 when
// empty), empty/full flags, an error flag and the occupancy. Look, push and
// any failing request answer straight from idle; a pop that leaves at least
// one word passes through the fetch state, because the new front or rear word
// comes back from the registered RAM read. The front and rear words are cached
// in registers, so only pops touch the RAM read port. A push into a full queue
// is dropped and a pop from an empty queue changes nothing; both set op_error.
// Kind codes 5 to 7 act as look only. No clearing pass runs after reset.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    deq_in_if.sink     req,
    deq_out_if.source  rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic          res_valid;
    res_t          res;
    logic [CW-1:0] res_occ;
    logic          out_free;

    logic          out_valid_reg, out_valid_next;
    res_t          out_res_reg;
    logic [CW-1:0] out_occ_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .res_occ   (res_occ)
    );

    // output register, reloaded only when it is empty or its current transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
            out_occ_reg <= res_occ;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.front_value = out_res_reg.front_value;
    assign rsp.rear_value  = out_res_reg.rear_value;
    assign rsp.is_empty    = out_res_reg.is_empty;
    assign rsp.is_full     = out_res_reg.is_full;
    assign rsp.op_error    = out_res_reg.op_error;
    assign rsp.occupancy   = out_occ_reg;

    a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (32'(rsp.occupancy) <= 32'(DEPTH)))
        else $error("occupancy above depth");

    a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.is_empty == (rsp.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_empty_ends : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.is_empty |-> (rsp.front_value == -32'sd1)
                                      && (rsp.rear_value == -32'sd1))
        else $error("empty queue shows a word");

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> rsp.valid || !req.ready)
        else $error("request transfer produced no response");

endmodule

// File: rtl/deq_ram.sv
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    deq_in_if.sink                     req,
    input  logic                       out_free,
    output logic                       res_valid,
    output res_t                       res,
    output logic [$clog2(DEPTH+1)-1:0] res_occ
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    word_t           front_reg, front_next;
    word_t           rear_reg, rear_next;
    logic            fetch_front_reg, fetch_front_next;

    logic            accept;
    logic            was_empty, was_full, empty_now;
    logic [AW-1:0]   head_inc, head_dec;
    logic [SW-1:0]   tail_sum, tail_wrap, last_sum, last_wrap;
    logic            need_fetch, op_err;
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [WORD_W-1:0] rd_data;

    assign accept    = req.valid && req.ready;
    assign was_empty = (count_reg == '0);
    assign was_full  = (count_reg == CW'(DEPTH));

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    // slot after the rear, and the slot of the rear after a pop at the rear
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
    assign last_sum  = tail_sum - SW'(2);
    assign last_wrap = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;

    always_comb
    begin
        head_next        = head_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        fetch_front_next = fetch_front_reg;
        wr_en            = 1'b0;
        wr_addr          = tail_wrap[AW-1:0];
        rd_en            = 1'b0;
        rd_addr          = head_inc;
        need_fetch       = 1'b0;
        op_err           = 1'b0;
        if (state_reg == ST_FETCH)
        begin
            if (fetch_front_reg)
            begin
                front_next = word_t'(rd_data);
            end
            else
            begin
                rear_next = word_t'(rd_data);
            end
        end
        else if (accept)
        begin
            case (kind_t'(req.kind))
                KIND_PUSH_FRONT:
                begin
                    if (was_full)
                    begin
                        op_err = 1'b1;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        count_next = count_reg + CW'(1);
                        front_next = req.push_value;
                        if (was_empty)
                        begin
                            rear_next = req.push_value;
                        end
                    end
                end
                KIND_PUSH_REAR:
                begin
                    if (was_full)
                    begin
                        op_err = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        rear_next  = req.push_value;
                        if (was_empty)
                        begin
                            front_next = req.push_value;
                        end
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (was_empty)
                    begin
                        op_err = 1'b1;
                    end
                    else
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                        if (count_reg != CW'(1))
                        begin
                            rd_en            = 1'b1;
                            rd_addr          = head_inc;
                            need_fetch       = 1'b1;
                            fetch_front_next = 1'b1;
                        end
                    end
                end
                KIND_POP_REAR:
                begin
                    if (was_empty)
                    begin
                        op_err = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        if (count_reg != CW'(1))
                        begin
                            rd_en            = 1'b1;
                            rd_addr          = last_wrap[AW-1:0];
                            need_fetch       = 1'b1;
                            fetch_front_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && need_fetch)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake and result strobe
    always_comb
    begin
        req.ready = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = out_free;
                res_valid = accept && !need_fetch;
            end
            ST_FETCH:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign empty_now       = (count_next == '0);
    assign res.front_value = empty_now ? '1 : front_next;
    assign res.rear_value  = empty_now ? '1 : rear_next;
    assign res.is_empty    = empty_now;
    assign res.is_full     = (count_next == CW'(DEPTH));
    assign res.op_error    = op_err;
    assign res_occ         = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            fetch_front_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            fetch_front_reg <= fetch_front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
    end

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// File: tb/sv/tb.sv
module tb;
    import deq_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int PHASE_ITEMS = 350;
    localparam int HOLD_CYC    = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYC    = 20;
    localparam int SHOW_MAX    = 10;
    localparam int N_DIR       = 24;

    // kind codes outside the defined set behave as look only
    localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

    localparam word_t W_NONE = -32'sd1;
    localparam word_t W_MAX  = 32'sh7fff_ffff;
    localparam word_t W_MIN  = 32'sh8000_0000;

    typedef enum int {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIX
    } seg_t;

    typedef struct packed {
        word_t            front;
        word_t            rear;
        logic             empty;
        logic             full;
        logic             err;
        logic [OCC_W-1:0] occ;
    } deq_view_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        word_t             value;
        logic              lit;
        deq_view_t         view;
    } dir_row_t;

    localparam deq_view_t VIEW_EMPTY = '{W_NONE, W_NONE, 1'b1, 1'b0, 1'b0, '0};
    localparam deq_view_t VIEW_UNDER = '{W_NONE, W_NONE, 1'b1, 1'b0, 1'b1, '0};
    localparam deq_view_t VIEW_NA    = '0;

    logic clk;
    logic rst_n;

    deq_in_if                   in_ch ();
    deq_out_if #(.OCC_W(OCC_W)) out_ch ();

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (in_ch),
        .rsp  (out_ch)
    );

    // directed rows, literal views only where they are obvious
    dir_row_t dir_tab [N_DIR] = '{
        '{KIND_LOOK,       32'sd0,        1'b1, VIEW_EMPTY},
        '{KIND_POP_FRONT,  32'sd0,        1'b1, VIEW_UNDER},
        '{KIND_POP_REAR,   W_MAX,         1'b1, VIEW_UNDER},
        '{KIND_SPARE_HI,   W_MIN,         1'b1, VIEW_EMPTY},
        '{KIND_PUSH_FRONT, W_MAX,         1'b1, '{W_MAX, W_MAX, 1'b0, 1'b0, 1'b0, 7'd1}},
        '{KIND_PUSH_REAR,  W_MIN,         1'b1, '{W_MAX, W_MIN, 1'b0, 1'b0, 1'b0, 7'd2}},
        '{KIND_PUSH_FRONT, W_NONE,        1'b0, VIEW_NA},
        '{KIND_PUSH_REAR,  32'sd0,        1'b0, VIEW_NA},
        '{KIND_SPARE_LO,   32'sh1234_5678, 1'b0, VIEW_NA},
        '{KIND_SPARE_MID,  W_NONE,        1'b0, VIEW_NA},
        '{KIND_LOOK,       32'shdead_beef, 1'b0, VIEW_NA},
        '{KIND_POP_FRONT,  W_MAX,         1'b0, VIEW_NA},
        '{KIND_POP_REAR,   W_MIN,         1'b0, VIEW_NA},
        '{KIND_POP_FRONT,  32'sd0,        1'b0, VIEW_NA},
        '{KIND_POP_REAR,   32'sd0,        1'b1, VIEW_EMPTY},
        '{KIND_POP_REAR,   32'sd0,        1'b1, VIEW_UNDER},
        '{KIND_PUSH_REAR,  32'sd1,        1'b1, '{32'sd1, 32'sd1, 1'b0, 1'b0, 1'b0, 7'd1}},
        '{KIND_POP_FRONT,  32'sd0,        1'b1, VIEW_EMPTY},
        '{KIND_PUSH_FRONT, W_MIN,         1'b0, VIEW_NA},
        '{KIND_PUSH_FRONT, 32'sh5555_5555, 1'b0, VIEW_NA},
        '{KIND_PUSH_REAR,  32'shaaaa_aaaa, 1'b0, VIEW_NA},
        '{KIND_POP_REAR,   32'sd0,        1'b0, VIEW_NA},
        '{KIND_POP_FRONT,  32'sd0,        1'b0, VIEW_NA},
        '{KIND_LOOK,       W_MAX,         1'b0, VIEW_NA}
    };

    // shadow of the deque contents
    word_t deq_mem [DEPTH];
    int    deq_head  = 0;
    int    deq_count = 0;

    deq_view_t due_views [$];
    int        n_acc        = 0;
    int        n_err        = 0;
    int        idle_cycles  = 0;
    int        n_sent       = 0;
    int        plan_cnt     = 0;
    int        src_idle_pct = 0;
    int        snk_stall_pct = 0;
    int        hold_seq     = 0;

    function automatic deq_view_t apply_op(logic [KIND_W-1:0] k, word_t v);
        deq_view_t r;
        logic      err;
        err = 1'b0;
        case (k)
            KIND_PUSH_FRONT:
                if (deq_count == DEPTH)
                    err = 1'b1;
                else
                begin
                    deq_head = (deq_head + DEPTH - 1) % DEPTH;
                    deq_mem[deq_head] = v;
                    deq_count++;
                end
            KIND_PUSH_REAR:
                if (deq_count == DEPTH)
                    err = 1'b1;
                else
                begin
                    deq_mem[(deq_head + deq_count) % DEPTH] = v;
                    deq_count++;
                end
            KIND_POP_FRONT:
                if (deq_count == 0)
                    err = 1'b1;
                else
                begin
                    deq_head = (deq_head + 1) % DEPTH;
                    deq_count--;
                end
            KIND_POP_REAR:
                if (deq_count == 0)
                    err = 1'b1;
                else
                    deq_count--;
            default:
                ;
        endcase
        r.front = W_NONE;
        r.rear  = W_NONE;
        if (deq_count != 0)
        begin
            r.front = deq_mem[deq_head];
            r.rear  = deq_mem[(deq_head + deq_count - 1) % DEPTH];
        end
        r.empty = (deq_count == 0);
        r.full  = (deq_count == DEPTH);
        r.err   = err;
        r.occ   = deq_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(15))
            0:       return W_MIN;
            1:       return W_MAX;
            2:       return 32'sd0;
            3:       return W_NONE;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic send_op(input logic [KIND_W-1:0] k, input word_t v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= k;
        in_ch.push_value <= v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if ((k == KIND_PUSH_FRONT || k == KIND_PUSH_REAR) && plan_cnt < DEPTH)
            plan_cnt++;
        else if ((k == KIND_POP_FRONT || k == KIND_POP_REAR) && plan_cnt > 0)
            plan_cnt--;
        n_sent++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYC;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // transfer monitor, predictor update and watchdog
    always @(posedge clk)
    begin
        deq_view_t want;
        deq_view_t got;
        if (rst_n)
        begin
            idle_cycles++;
            if (in_ch.valid && in_ch.ready)
            begin
                idle_cycles = 0;
                want = apply_op(in_ch.kind, in_ch.push_value);
                if (n_acc < N_DIR && dir_tab[n_acc].lit)
                    want = dir_tab[n_acc].view;
                due_views.push_back(want);
                n_acc++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                idle_cycles = 0;
                got = '{out_ch.front_value, out_ch.rear_value, out_ch.is_empty,
                        out_ch.is_full, out_ch.op_error, out_ch.occupancy};
                if (due_views.size() == 0)
                begin
                    n_err++;
                    if (n_err <= SHOW_MAX)
                        $display("unexpected result: front %h rear %h occ %0d",
                                 got.front, got.rear, got.occ);
                end
                else
                begin
                    want = due_views.pop_front();
                    if (got !== want)
                    begin
                        n_err++;
                        if (n_err <= SHOW_MAX)
                        begin
                            $write("mismatch: exp front %h rear %h e%b f%b err%b occ %0d",
                                   want.front, want.rear, want.empty, want.full,
                                   want.err, want.occ);
                            $display(" | got front %h rear %h e%b f%b err%b occ %0d",
                                     got.front, got.rear, got.empty, got.full,
                                     got.err, got.occ);
                        end
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int                phase;
        int                seg_no;
        int                start;
        int                pick;
        int                reps;
        seg_t              seg;
        logic [KIND_W-1:0] k;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_LOOK;
        in_ch.push_value = '0;
        rst_n            = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_op(dir_tab[i].kind, dir_tab[i].value);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
                default: begin src_idle_pct = 26; snk_stall_pct = 26; end
            endcase
            start  = n_sent;
            seg_no = 0;
            while (n_sent - start < PHASE_ITEMS)
            begin
                // the first phase opens with overflow and underflow runs
                if (phase == 0 && seg_no == 0)
                    seg = SEG_FILL;
                else if (phase == 0 && seg_no == 1)
                    seg = SEG_DRAIN;
                else
                begin
                    pick = $urandom_range(99);
                    seg = (pick < 30) ? SEG_FILL : (pick < 60) ? SEG_DRAIN : SEG_MIX;
                end
                // receiver holds off while the sender keeps offering
                if (seg_no == 2 && (phase == 0 || phase == 3))
                    hold_seq <= hold_seq + 1;
                case (seg)
                    SEG_FILL:
                    begin
                        while (plan_cnt < DEPTH)
                            send_op($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR,
                                    rand_word());
                        reps = $urandom_range(3, 1);
                        repeat (reps)
                            send_op($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR,
                                    rand_word());
                    end
                    SEG_DRAIN:
                    begin
                        while (plan_cnt > 0)
                            send_op($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_REAR,
                                    rand_word());
                        reps = $urandom_range(3, 1);
                        repeat (reps)
                            send_op($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_REAR,
                                    rand_word());
                    end
                    default:
                    begin
                        reps = $urandom_range(40, 10);
                        repeat (reps)
                        begin
                            pick = $urandom_range(99);
                            if (pick < 20)
                                k = KIND_PUSH_FRONT;
                            else if (pick < 40)
                                k = KIND_PUSH_REAR;
                            else if (pick < 58)
                                k = KIND_POP_FRONT;
                            else if (pick < 76)
                                k = KIND_POP_REAR;
                            else if (pick < 90)
                                k = KIND_LOOK;
                            else
                                k = KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
                            send_op(k, rand_word());
                        end
                    end
                endcase
                seg_no++;
            end
        end
        in_ch.valid <= 1'b0;

        while (due_views.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        if (n_err == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
